### hdl/rfsa_pkg.sv
// Package for the radio frame sample averager: field widths, codes, frame
// constants, reset values and the structs shared by the core and its units.
// Depends on nothing; compile it first.
package rfsa_pkg;

  localparam int FRAME_BYTES = 15;

  localparam int ACTION_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int ERR_W      = 2;
  localparam int ADDR_W     = 16;
  localparam int RSSI_W     = 8;
  localparam int SUM_W      = 32;
  localparam int WORD_W     = 16;
  localparam int COUNT_W    = 16;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Input actions.
  localparam logic [ACTION_W-1:0] ACT_BYTE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_START  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LENGTH = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TYPE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NS_TEMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NS_PRES = 2'd2;

  // Frame format.
  localparam logic [BYTE_W-1:0] START_BYTE   = 8'h7E;
  localparam logic [BYTE_W-1:0] FRAME_TYPE   = 8'h81;
  localparam logic [WORD_W-1:0] FRAME_LENGTH = 16'd11;

  // Reset values of the configuration registers.
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd6;
  localparam logic [WORD_W-1:0] NS_TEMP_RESET = 16'd300;
  localparam logic [WORD_W-1:0] NS_PRES_RESET = 16'd10000;

  localparam logic [COUNT_W-1:0] SAMPLES_MAX = 16'hFFFF;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ERR_W-1:0]   error_code;
    logic [ADDR_W-1:0]  source_address;
    logic [RSSI_W-1:0]  signal_strength;
    logic [SUM_W-1:0]   pulses;
    logic [WORD_W-1:0]  temperature;
    logic [WORD_W-1:0]  pressure;
    logic [COUNT_W-1:0] sample_count;
  } result_t;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

### hdl/rfsa_if.sv
// Handshake interfaces of the radio frame sample averager: input items,
// result items and configuration writes. Widths come from rfsa_pkg.
interface rfsa_in_if;
  logic                          valid;
  logic                          ready;
  logic [rfsa_pkg::ACTION_W-1:0] action;
  logic [rfsa_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface rfsa_out_if;
  logic                         valid;
  logic                         ready;
  logic [rfsa_pkg::KIND_W-1:0]  kind;
  logic [rfsa_pkg::ERR_W-1:0]   error_code;
  logic [rfsa_pkg::ADDR_W-1:0]  source_address;
  logic [rfsa_pkg::RSSI_W-1:0]  signal_strength;
  logic [rfsa_pkg::SUM_W-1:0]   pulses;
  logic [rfsa_pkg::WORD_W-1:0]  temperature;
  logic [rfsa_pkg::WORD_W-1:0]  pressure;
  logic [rfsa_pkg::COUNT_W-1:0] sample_count;

  modport source (output valid, kind, error_code, source_address, signal_strength,
                  pulses, temperature, pressure, sample_count, input ready);
  modport sink   (input valid, kind, error_code, source_address, signal_strength,
                  pulses, temperature, pressure, sample_count, output ready);
endinterface

interface rfsa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rfsa_pkg::CFG_IDX_W-1:0]  index;
  logic [rfsa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/rfsa_serial_acc.sv
// Bit-serial accumulator holding the pulse, temperature and pressure sums.
// One full adder per sum, one bit per cycle. Depends on rfsa_pkg.
module rfsa_serial_acc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rfsa_pkg::acc_cmd_t           cmd_i,
  input  logic [rfsa_pkg::WORD_W-1:0]  pulse_i,
  input  logic [rfsa_pkg::WORD_W-1:0]  temp_i,
  input  logic [rfsa_pkg::WORD_W-1:0]  pres_i,
  output logic [rfsa_pkg::SUM_W-1:0]   pulse_sum_o,
  output logic [rfsa_pkg::SUM_W-1:0]   temp_sum_o,
  output logic [rfsa_pkg::SUM_W-1:0]   pres_sum_o,
  output rfsa_pkg::unit_sts_t          sts_o
);
  import rfsa_pkg::*;

  localparam int Lanes = 3;
  localparam int CntW  = $clog2(SUM_W);
  localparam logic [CntW-1:0] LastBit = CntW'(SUM_W - 1);

  logic [SUM_W-1:0] sum_q [Lanes];
  logic [SUM_W-1:0] add_q [Lanes];
  logic             carry_q [Lanes];
  logic             sbit [Lanes];
  logic             cout [Lanes];
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      sbit[l] = sum_q[l][0] ^ add_q[l][0] ^ carry_q[l];
      cout[l] = (sum_q[l][0] & add_q[l][0]) | (carry_q[l] & (sum_q[l][0] ^ add_q[l][0]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < Lanes; l++) begin
        sum_q[l]   <= '0;
        add_q[l]   <= '0;
        carry_q[l] <= 1'b0;
      end
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.clear) begin
        for (int l = 0; l < Lanes; l++) begin
          sum_q[l] <= '0;
        end
      end else if (cmd_i.start) begin
        add_q[0] <= SUM_W'(pulse_i);
        add_q[1] <= SUM_W'(temp_i);
        add_q[2] <= SUM_W'(pres_i);
        for (int l = 0; l < Lanes; l++) begin
          carry_q[l] <= 1'b0;
        end
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // The sums rotate right; after a full word they are back in place.
        for (int l = 0; l < Lanes; l++) begin
          sum_q[l]   <= {sbit[l], sum_q[l][SUM_W-1:1]};
          add_q[l]   <= {1'b0, add_q[l][SUM_W-1:1]};
          carry_q[l] <= cout[l];
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign pulse_sum_o = sum_q[0];
  assign temp_sum_o  = sum_q[1];
  assign pres_sum_o  = sum_q[2];
  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;

endmodule

### hdl/rfsa_serial_div.sv
// Restoring divider producing one quotient bit per cycle, for averaging a
// 32-bit sum over the 16-bit sample count. Depends on rfsa_pkg.
module rfsa_serial_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rfsa_pkg::SUM_W-1:0]   dividend_i,
  input  logic [rfsa_pkg::COUNT_W-1:0] divisor_i,
  output logic [rfsa_pkg::SUM_W-1:0]   quotient_o,
  output rfsa_pkg::unit_sts_t          sts_o
);
  import rfsa_pkg::*;

  localparam int CntW = $clog2(SUM_W);
  localparam logic [CntW-1:0] LastBit = CntW'(SUM_W - 1);

  logic [COUNT_W-1:0] rem_q;
  logic [COUNT_W-1:0] rem_d;
  logic [COUNT_W-1:0] div_q;
  logic [SUM_W-1:0]   quo_q;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               ge;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;

  // The dividend leaves quo_q at the top while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        div_q  <= divisor_i;
        quo_q  <= dividend_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[SUM_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

### hdl/radio_frame_sample_averager_core.sv
// Top level of the radio frame sample averager: frame store, control
// sequencer, configuration registers and result register.
// Depends on rfsa_pkg, rfsa_if, rfsa_serial_acc and rfsa_serial_div.
//
// Usage: every input item on in_i carries an action and a byte. A byte item
// fills the frame store, a tick item advances the frame timeout, a report
// item asks for the sums and averages, and a clear item zeroes the sums and
// the sample count. Results leave on out_o, at most one per input item, and
// configuration writes arrive on cfg_i, which is always ready.
// Byte items, clear items and ticks that do not end a frame produce no
// result. A tick that ends a frame leads to the frame check; an accepted
// frame that is summed then passes through the bit-serial accumulator
// before its result is loaded. A report with samples runs two restoring
// dividers side by side; a report with no samples needs no division.
// The result register decouples the sides: a new item is taken while a
// result waits, and a finished result waits in its own state only while the
// register is still full. Reset clears the control state, the sums, the
// sample count and loads the configuration defaults; the frame store is not
// cleared, as the check reads only bytes that were received.
module radio_frame_sample_averager_core #(
  parameter int FrameBytes = rfsa_pkg::FRAME_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfsa_in_if.sink    in_i,
  rfsa_out_if.source out_o,
  rfsa_cfg_if.sink   cfg_i
);
  import rfsa_pkg::*;

  localparam int IdxW = $clog2(FrameBytes);
  localparam int CntW = $clog2(FrameBytes + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               recv_q, recv_d;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [COUNT_W-1:0] samples_q, samples_d;
  result_t            res_q, res_d;
  result_t            out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [TICK_W-1:0]  timeout_q;
  logic [WORD_W-1:0]  ns_temp_q;
  logic [WORD_W-1:0]  ns_pres_q;

  logic [BYTE_W-1:0]  store_q [FrameBytes];
  logic               store_we;
  logic [IdxW-1:0]    store_addr;

  acc_cmd_t           acc_cmd;
  unit_sts_t          acc_sts;
  logic [SUM_W-1:0]   pulse_sum, temp_sum, pres_sum;
  logic               div_start;
  unit_sts_t          tdiv_sts, pdiv_sts;
  logic [SUM_W-1:0]   tquo, pquo;

  logic               in_acc;
  logic [ERR_W-1:0]   frame_err;
  logic [WORD_W-1:0]  w_len, w_addr, w_pulse, w_temp, w_pres;
  logic [BYTE_W-1:0]  b_start, b_type, b_rssi;

  // Bytes at or beyond the received count read as zero.
  function automatic logic [BYTE_W-1:0] frame_byte(input logic [IdxW-1:0] pos,
                                                   input logic [CntW-1:0] cnt);
    logic [BYTE_W-1:0] val;
    val = '0;
    if (CntW'(pos) < cnt) begin
      val = store_q[pos];
    end
    return val;
  endfunction

  always_comb begin
    b_start = frame_byte(IdxW'(0), count_q);
    w_len   = {frame_byte(IdxW'(1), count_q), frame_byte(IdxW'(2), count_q)};
    b_type  = frame_byte(IdxW'(3), count_q);
    w_addr  = {frame_byte(IdxW'(4), count_q), frame_byte(IdxW'(5), count_q)};
    b_rssi  = frame_byte(IdxW'(6), count_q);
    w_pulse = {frame_byte(IdxW'(8), count_q), frame_byte(IdxW'(9), count_q)};
    w_temp  = {frame_byte(IdxW'(10), count_q), frame_byte(IdxW'(11), count_q)};
    w_pres  = {frame_byte(IdxW'(12), count_q), frame_byte(IdxW'(13), count_q)};
    priority if (b_start != START_BYTE) begin
      frame_err = ERR_START;
    end else if (w_len != FRAME_LENGTH) begin
      frame_err = ERR_LENGTH;
    end else if (b_type != FRAME_TYPE) begin
      frame_err = ERR_TYPE;
    end else begin
      frame_err = ERR_NONE;
    end
  end

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    logic [TICK_W-1:0] tick_inc;
    tick_inc    = tick_q + 1'b1;
    state_d     = state_q;
    count_d     = count_q;
    recv_d      = recv_q;
    tick_d      = tick_q;
    samples_d   = samples_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    store_we    = 1'b0;
    store_addr  = '0;
    acc_cmd     = '0;
    div_start   = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.action)
            ACT_BYTE: begin
              if (!recv_q) begin
                store_we   = 1'b1;
                store_addr = '0;
                count_d    = CntW'(1);
                recv_d     = 1'b1;
                tick_d     = '0;
              end else if (count_q < CntW'(FrameBytes)) begin
                // A full frame drops further bytes.
                store_we   = 1'b1;
                store_addr = count_q[IdxW-1:0];
                count_d    = count_q + 1'b1;
              end
            end
            ACT_TICK: begin
              if (recv_q) begin
                tick_d = tick_inc;
                // A wrapped count also ends the frame.
                if ((tick_inc >= timeout_q) || (tick_inc == '0)) begin
                  state_d = S_CHECK;
                end
              end
            end
            ACT_REPORT: begin
              res_d              = '0;
              res_d.kind         = KIND_REPORT;
              res_d.pulses       = pulse_sum;
              res_d.sample_count = samples_q;
              if (samples_q == '0) begin
                res_d.temperature = ns_temp_q;
                res_d.pressure    = ns_pres_q;
                state_d           = S_EMIT;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            ACT_CLEAR: begin
              acc_cmd.clear = 1'b1;
              samples_d     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        res_d   = '0;
        recv_d  = 1'b0;
        count_d = '0;
        tick_d  = '0;
        if (frame_err != ERR_NONE) begin
          res_d.kind         = KIND_REJECT;
          res_d.error_code   = frame_err;
          res_d.sample_count = samples_q;
          state_d            = S_EMIT;
        end else begin
          res_d.kind            = KIND_ACCEPT;
          res_d.source_address  = w_addr;
          res_d.signal_strength = b_rssi;
          res_d.pulses          = SUM_W'(w_pulse);
          res_d.temperature     = w_temp;
          res_d.pressure        = w_pres;
          if (samples_q < SAMPLES_MAX) begin
            acc_cmd.start      = 1'b1;
            samples_d          = samples_q + 1'b1;
            res_d.sample_count = samples_q + 1'b1;
            state_d            = S_ACC;
          end else begin
            // Saturated count: report the frame but leave the sums alone.
            res_d.sample_count = samples_q;
            state_d            = S_EMIT;
          end
        end
      end
      S_ACC: begin
        if (acc_sts.done) begin
          state_d = S_EMIT;
        end
      end
      S_DIV: begin
        if (tdiv_sts.done) begin
          res_d.temperature = tquo[WORD_W-1:0];
          res_d.pressure    = pquo[WORD_W-1:0];
          state_d           = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      recv_q      <= 1'b0;
      tick_q      <= '0;
      samples_q   <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      recv_q      <= recv_d;
      tick_q      <= tick_d;
      samples_q   <= samples_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_addr] <= in_i.data_byte;
    end
  end

  // Configuration registers; writes to an unused index are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      ns_temp_q <= NS_TEMP_RESET;
      ns_pres_q <= NS_PRES_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_TIMEOUT: timeout_q <= cfg_i.data[TICK_W-1:0];
        REG_NS_TEMP: ns_temp_q <= cfg_i.data[WORD_W-1:0];
        REG_NS_PRES: ns_pres_q <= cfg_i.data[WORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfsa_serial_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (acc_cmd),
    .pulse_i     (w_pulse),
    .temp_i      (w_temp),
    .pres_i      (w_pres),
    .pulse_sum_o (pulse_sum),
    .temp_sum_o  (temp_sum),
    .pres_sum_o  (pres_sum),
    .sts_o       (acc_sts)
  );

  rfsa_serial_div u_tdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (temp_sum),
    .divisor_i  (samples_q),
    .quotient_o (tquo),
    .sts_o      (tdiv_sts)
  );

  rfsa_serial_div u_pdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pres_sum),
    .divisor_i  (samples_q),
    .quotient_o (pquo),
    .sts_o      (pdiv_sts)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.kind            = out_q.kind;
  assign out_o.error_code      = out_q.error_code;
  assign out_o.source_address  = out_q.source_address;
  assign out_o.signal_strength = out_q.signal_strength;
  assign out_o.pulses          = out_q.pulses;
  assign out_o.temperature     = out_q.temperature;
  assign out_o.pressure        = out_q.pressure;
  assign out_o.sample_count    = out_q.sample_count;

`ifndef SYNTHESIS
  // While waiting on the accumulator it must be running or just finished.
  a_acc_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (acc_sts.busy || acc_sts.done))
    else $error("sequencer waits on an idle accumulator");

  // Both dividers start together and must finish together.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tdiv_sts.done == pdiv_sts.done) && (tdiv_sts.busy == pdiv_sts.busy))
    else $error("dividers out of step");

  // An idle receiver holds no bytes, and the count never passes the store.
  a_count_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!recv_q |-> (count_q == '0)) && (count_q <= CntW'(FrameBytes)))
    else $error("frame byte count inconsistent");

  // A frame check always clears reception in the following cycle.
  a_check_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |=> !recv_q)
    else $error("frame still receiving after check");
`endif

endmodule
